// ===== rtl/integer_radix_formatter_macros.svh =====
// Assertion macros shared by the integer radix formatter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef INTEGER_RADIX_FORMATTER_MACROS_SVH
`define INTEGER_RADIX_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/irf_pkg.sv =====
// Types, constants and character helpers for the integer radix formatter.
// No dependencies; used by the other RTL modules by scoped names.
package irf_pkg;

	localparam int VAL_W     = 32;
	localparam int BASE_W    = 6;
	localparam int FW_W      = 7;
	localparam int MD_W      = 6;
	localparam int FLAGS_W   = 7;
	localparam int CHAR_W    = 8;
	localparam int LEN_W     = 9;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = VAL_W / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam int FLG_ZERO   = 0;
	localparam int FLG_SIGNED = 1;
	localparam int FLG_PLUS   = 2;
	localparam int FLG_SPACE  = 3;
	localparam int FLG_LEFT   = 4;
	localparam int FLG_PREFIX = 5;
	localparam int FLG_LOWER  = 6;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

	typedef enum logic [2:0] {
		IRF_IDLE,
		IRF_CHECK,
		IRF_DIV_WAIT,
		IRF_PLAN,
		IRF_EMIT,
		IRF_ERR
	} irf_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic digit_wr;
		logic plan;
		logic emit;
		logic err;
	} irf_cmd_t;

	typedef struct packed {
		logic base_ok;
		logic div_done;
		logic digit_last;
		logic emit_last;
	} irf_sts_t;

	function automatic logic [CHAR_W-1:0] irf_digit_char(input logic [BASE_W-1:0] d,
			input logic lower);
		logic [CHAR_W-1:0] dx;
		dx = {2'b00, d};
		if (d < 6'd10)
			return CH_ZERO + dx;
		else
			return (lower ? CH_LO_A : CH_UP_A) + dx - 8'd10;
	endfunction

endpackage

// ===== rtl/integer_radix_formatter.sv =====
// Integer radix formatter top level: printf-style integer conversion to ASCII.
// Depends on irf_pkg, irf_ctrl, irf_dp (and irf_div below it).
//
//  channel  | handshake      | payload
//  ---------+----------------+--------------------------------------------------
//  command  | start / busy   | value, base, min_width, min_digits, format_flags
//  result   | strobe         | out_char, last_char, bad_base
//
// Each digit costs one pass of the shared four-bit-per-cycle divider; an invalid base
// goes from the base check straight to the error state and back to idle.
// Characters leave one per cycle, in the cycle after the internal emit step; the last
// one is shown while the next command is already accepted.
// Reset clears the controller and the result strobe; no clearing pass is needed.
// The receiver cannot stall: each strobe cycle is one delivered result.
module integer_radix_formatter #(
	parameter int MAX_FIELD   = 64,
	parameter int DIGIT_SLOTS = 36
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [irf_pkg::VAL_W-1:0]          value,
	input  logic [irf_pkg::BASE_W-1:0]         base,
	input  logic [irf_pkg::FW_W-1:0]           min_width,
	input  logic [irf_pkg::MD_W-1:0]           min_digits,
	input  logic [irf_pkg::FLAGS_W-1:0]        format_flags,
	output logic                               strobe,
	output logic [irf_pkg::CHAR_W-1:0]         out_char,
	output logic                               last_char,
	output logic                               bad_base
);

	irf_pkg::irf_cmd_t cmd;
	irf_pkg::irf_sts_t sts;

	irf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	irf_dp #(
		.MAX_FIELD   (MAX_FIELD),
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.base         (base),
		.min_width    (min_width),
		.min_digits   (min_digits),
		.format_flags (format_flags),
		.strobe       (strobe),
		.out_char     (out_char),
		.last_char    (last_char),
		.bad_base     (bad_base)
	);

endmodule

// ===== rtl/irf_div.sv =====
// Iterative unsigned divider: 32-bit dividend by a 6-bit radix, four bits a cycle.
// Depends on irf_pkg for widths.
module irf_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [irf_pkg::VAL_W-1:0]          dividend,
	input  logic [irf_pkg::BASE_W-1:0]         divisor,
	output logic                                done,
	output logic [irf_pkg::VAL_W-1:0]          quotient,
	output logic [irf_pkg::BASE_W-1:0]         remainder
);

	logic [irf_pkg::VAL_W-1:0]  quo_q;
	logic [irf_pkg::BASE_W-1:0] rem_q;
	logic [irf_pkg::DIV_CW-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;

	logic [irf_pkg::VAL_W-1:0]  q_n;
	logic [irf_pkg::BASE_W-1:0] r_n;
	logic [irf_pkg::BASE_W:0]   r_w;
	logic                       last_step;

	// Restoring long division, DIV_BITS dependent steps per cycle.
	always_comb begin
		q_n = quo_q;
		r_n = rem_q;
		r_w = '0;
		for (int i = 0; i < irf_pkg::DIV_BITS; i++) begin
			r_w = {r_n, q_n[irf_pkg::VAL_W-1]};
			q_n = {q_n[irf_pkg::VAL_W-2:0], 1'b0};
			if (r_w >= {1'b0, divisor}) begin
				r_w = r_w - {1'b0, divisor};
				q_n[0] = 1'b1;
			end
			r_n = r_w[irf_pkg::BASE_W-1:0];
		end
	end

	assign last_step = (cnt_q == irf_pkg::DIV_CW'(irf_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last_step;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= q_n;
			rem_q <= r_n;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/irf_dp.sv =====
// Formatter datapath: operand capture, divider, digit store, layout plan, character stage.
// Depends on irf_pkg, irf_div and integer_radix_formatter_macros.svh.
`include "integer_radix_formatter_macros.svh"

module irf_dp #(
	parameter int MAX_FIELD   = 64,
	parameter int DIGIT_SLOTS = 36
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  irf_pkg::irf_cmd_t                  cmd,
	output irf_pkg::irf_sts_t                  sts,
	input  logic [irf_pkg::VAL_W-1:0]          value,
	input  logic [irf_pkg::BASE_W-1:0]         base,
	input  logic [irf_pkg::FW_W-1:0]           min_width,
	input  logic [irf_pkg::MD_W-1:0]           min_digits,
	input  logic [irf_pkg::FLAGS_W-1:0]        format_flags,
	output logic                               strobe,
	output logic [irf_pkg::CHAR_W-1:0]         out_char,
	output logic                               last_char,
	output logic                               bad_base
);

	localparam int DIG_AW = $clog2(DIGIT_SLOTS);
	localparam int NDW    = $clog2(DIGIT_SLOTS + 1);
	localparam int POS_W  = $clog2(MAX_FIELD);
	localparam int LEN_W  = irf_pkg::LEN_W;

	// Captured operands
	logic [irf_pkg::VAL_W-1:0]  num_q;
	logic [irf_pkg::BASE_W-1:0] base_q;
	logic [irf_pkg::FW_W-1:0]   fw_q;
	logic [irf_pkg::MD_W-1:0]   md_q;
	logic [irf_pkg::CHAR_W-1:0] sign_q;
	logic [1:0]                 pre_len_q;
	logic                       zero_q;
	logic                       left_q;
	logic                       lower_q;
	logic                       base_ok_q;
	logic                       neg;

	// Digit store
	logic [irf_pkg::BASE_W-1:0] digit_mem_q [DIGIT_SLOTS];
	logic [NDW-1:0]             nd_q;

	// Divider
	logic                       div_done;
	logic [irf_pkg::VAL_W-1:0]  div_quo;
	logic [irf_pkg::BASE_W-1:0] div_rem;

	// Layout plan
	logic [LEN_W-1:0]        b1_q, b2_q, b3_q, b5_q, b6_q, dtop_q;
	logic [POS_W-1:0]        last_pos_q;
	logic [POS_W-1:0]        pos_q;
	logic [LEN_W-1:0]        nd_x, prec, core, pad, lead, padz, trail, total, cap;
	logic signed [LEN_W-1:0] size_s;
	logic                    has_sign;

	// Character stage
	logic [LEN_W-1:0]           posx;
	logic                       in_dig;
	logic [DIG_AW-1:0]          dig_addr;
	logic [NDW-1:0]             dig_addr_x;
	logic [irf_pkg::CHAR_W-1:0] ch;
	logic                       valid_s1, last_s1, err_s1, dig_s1;
	logic [irf_pkg::CHAR_W-1:0] char_s1;
	logic [irf_pkg::BASE_W-1:0] rd_s1;

	assign neg = format_flags[irf_pkg::FLG_SIGNED] && value[irf_pkg::VAL_W-1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q     <= neg ? (irf_pkg::VAL_W'(0) - value) : value;
			base_q    <= base;
			fw_q      <= min_width;
			md_q      <= min_digits;
			base_ok_q <= (base >= irf_pkg::BASE_MIN) && (base <= irf_pkg::BASE_MAX);
			left_q    <= format_flags[irf_pkg::FLG_LEFT];
			zero_q    <= format_flags[irf_pkg::FLG_ZERO] && !format_flags[irf_pkg::FLG_LEFT];
			lower_q   <= format_flags[irf_pkg::FLG_LOWER];
			if (neg)
				sign_q <= irf_pkg::CH_MINUS;
			else if (format_flags[irf_pkg::FLG_PLUS])
				sign_q <= irf_pkg::CH_PLUS;
			else if (format_flags[irf_pkg::FLG_SPACE])
				sign_q <= irf_pkg::CH_SPACE;
			else
				sign_q <= irf_pkg::CH_NONE;
			if (!format_flags[irf_pkg::FLG_PREFIX])
				pre_len_q <= 2'd0;
			else if (base == irf_pkg::BASE_HEX)
				pre_len_q <= 2'd2;
			else if (base == irf_pkg::BASE_OCT)
				pre_len_q <= 2'd1;
			else
				pre_len_q <= 2'd0;
		end else if (cmd.digit_wr) begin
			num_q <= div_quo;
		end
	end

	irf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (num_q),
		.divisor   (base_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nd_q <= '0;
		else if (cmd.load)
			nd_q <= '0;
		else if (cmd.digit_wr)
			nd_q <= nd_q + 1'b1;
	end

	// Digits land least significant first
	always_ff @(posedge clk) begin
		if (cmd.digit_wr)
			digit_mem_q[nd_q[DIG_AW-1:0]] <= div_rem;
		if (cmd.emit)
			rd_s1 <= digit_mem_q[dig_addr];
	end

	assign sts.base_ok    = base_ok_q;
	assign sts.div_done   = div_done;
	assign sts.digit_last = (div_quo == '0) || (nd_q == NDW'(DIGIT_SLOTS - 1));
	assign sts.emit_last  = (pos_q == last_pos_q);

	// Layout: lead spaces, sign, prefix, zero pad, precision zeros, digits, trail spaces
	always_comb begin
		has_sign = (sign_q != irf_pkg::CH_NONE);
		nd_x     = LEN_W'(nd_q);
		prec     = (nd_x > LEN_W'(md_q)) ? nd_x : LEN_W'(md_q);
		core     = LEN_W'(has_sign) + LEN_W'(pre_len_q) + prec;
		size_s   = signed'(LEN_W'(fw_q)) - signed'(core);
		pad      = size_s[LEN_W-1] ? '0 : LEN_W'(size_s);
		lead     = (!zero_q && !left_q) ? pad : '0;
		padz     = zero_q ? pad : '0;
		trail    = left_q ? pad : '0;
		total    = core + lead + padz + trail;
		cap      = (total > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : total;
	end

	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			b1_q       <= lead;
			b2_q       <= lead + LEN_W'(has_sign);
			b3_q       <= lead + LEN_W'(has_sign) + LEN_W'(pre_len_q);
			b5_q       <= lead + core - nd_x + padz;
			b6_q       <= lead + core + padz;
			dtop_q     <= lead + core + padz - LEN_W'(1);
			last_pos_q <= POS_W'(cap - LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (cmd.plan)
			pos_q <= '0;
		else if (cmd.emit)
			pos_q <= pos_q + 1'b1;
	end

	assign posx       = LEN_W'(pos_q);
	assign in_dig     = (posx >= b5_q) && (posx < b6_q);
	assign dig_addr   = DIG_AW'(dtop_q - posx);
	assign dig_addr_x = NDW'(dig_addr);

	always_comb begin
		if (posx < b1_q)
			ch = irf_pkg::CH_SPACE;
		else if (posx < b2_q)
			ch = sign_q;
		else if (posx < b3_q)
			ch = (posx == b2_q) ? irf_pkg::CH_ZERO :
				(lower_q ? irf_pkg::CH_LO_X : irf_pkg::CH_UP_X);
		else if (posx < b5_q)
			ch = irf_pkg::CH_ZERO;
		else
			ch = irf_pkg::CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			err_s1   <= 1'b0;
		end else begin
			valid_s1 <= cmd.emit || cmd.err;
			last_s1  <= cmd.err || (cmd.emit && sts.emit_last);
			err_s1   <= cmd.err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.err) begin
			char_s1 <= cmd.err ? irf_pkg::CH_NONE : ch;
			dig_s1  <= cmd.emit && in_dig;
		end
	end

	assign strobe    = valid_s1;
	assign last_char = last_s1;
	assign bad_base  = err_s1;
	assign out_char  = dig_s1 ? irf_pkg::irf_digit_char(rd_s1, lower_q) : char_s1;

	`IRF_ASSERT_IMP(a_rem_below_base, clk, arst_n, sts.div_done, div_rem < base_q, "remainder not below base")
	`IRF_ASSERT_IMP(a_digit_room, clk, arst_n, cmd.digit_wr, nd_q < NDW'(DIGIT_SLOTS), "digit store overflow")
	`IRF_ASSERT_IMP(a_digit_read_written, clk, arst_n, cmd.emit && in_dig, dig_addr_x < nd_q, "digit read beyond stored digits")

endmodule

// ===== rtl/irf_ctrl.sv =====
// Formatter controller: sequences capture, digit divisions, layout plan and emission.
// Depends on irf_pkg and integer_radix_formatter_macros.svh.
`include "integer_radix_formatter_macros.svh"

module irf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output irf_pkg::irf_cmd_t  cmd,
	input  irf_pkg::irf_sts_t  sts
);

	irf_pkg::irf_state_t state_q, state_d;
	logic [4:0]          cmd_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= irf_pkg::IRF_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			irf_pkg::IRF_IDLE: begin
				if (start)
					state_d = irf_pkg::IRF_CHECK;
			end
			irf_pkg::IRF_CHECK: begin
				state_d = sts.base_ok ? irf_pkg::IRF_DIV_WAIT : irf_pkg::IRF_ERR;
			end
			irf_pkg::IRF_DIV_WAIT: begin
				if (sts.div_done)
					state_d = sts.digit_last ? irf_pkg::IRF_PLAN : irf_pkg::IRF_CHECK;
			end
			irf_pkg::IRF_PLAN: begin
				state_d = irf_pkg::IRF_EMIT;
			end
			irf_pkg::IRF_EMIT: begin
				if (sts.emit_last)
					state_d = irf_pkg::IRF_IDLE;
			end
			irf_pkg::IRF_ERR: begin
				state_d = irf_pkg::IRF_IDLE;
			end
			default: begin
				state_d = irf_pkg::IRF_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		busy          = 1'b1;
		case (state_q)
			irf_pkg::IRF_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			irf_pkg::IRF_CHECK: begin
				cmd.div_start = sts.base_ok;
			end
			irf_pkg::IRF_DIV_WAIT: begin
				cmd.digit_wr = sts.div_done;
			end
			irf_pkg::IRF_PLAN: begin
				cmd.plan = 1'b1;
			end
			irf_pkg::IRF_EMIT: begin
				cmd.emit = 1'b1;
			end
			irf_pkg::IRF_ERR: begin
				cmd.err = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign cmd_vec = {cmd.load, cmd.div_start, cmd.plan, cmd.emit, cmd.err};

	`IRF_ASSERT_IMP(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0(cmd_vec), "conflicting commands")
	`IRF_ASSERT_NXT(a_start_waits, clk, arst_n, cmd.div_start, state_q == irf_pkg::IRF_DIV_WAIT, "division start not followed by wait")
	`IRF_ASSERT_NXT(a_emit_ends, clk, arst_n, cmd.emit && sts.emit_last, !busy, "block still busy after last character")

endmodule

// ===== test/tb_integer_radix_formatter.sv =====
// Self-checking testbench for integer_radix_formatter: directed table, then random commands.
// Depends on irf_pkg and the formatter RTL; expected text is typed or from a local predictor.
module tb_integer_radix_formatter;
	timeunit 1ns;
	timeprecision 1ps;

	import irf_pkg::*;

	localparam int TEXT_MAX    = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 24;

	localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1 << FLG_ZERO);
	localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1 << FLG_SIGNED);
	localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1 << FLG_PLUS);
	localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1 << FLG_SPACE);
	localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1 << FLG_LEFT);
	localparam logic [FLAGS_W-1:0] F_PREFIX = FLAGS_W'(1 << FLG_PREFIX);
	localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1 << FLG_LOWER);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} char_res_t;

	typedef char_res_t char_list_t[$];

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TEXT,
		ROW_BAD
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [VAL_W-1:0]   val;
		logic [BASE_W-1:0]  radix;
		logic [FW_W-1:0]    width;
		logic [MD_W-1:0]    precision;
		logic [FLAGS_W-1:0] flags;
		string              text;
	} dir_row_t;

	localparam int NUM_ROWS = 25;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [VAL_W-1:0]     value;
	logic [BASE_W-1:0]    base;
	logic [FW_W-1:0]      min_width;
	logic [MD_W-1:0]      min_digits;
	logic [FLAGS_W-1:0]   format_flags;
	logic                 strobe;
	logic [CHAR_W-1:0]    out_char;
	logic                 last_char;
	logic                 bad_base;

	char_res_t pending_chars[$];
	int        error_count;
	int        cycle_count;
	int        gap_pct;

	dir_row_t directed_rows[NUM_ROWS] = '{
		'{ROW_TEXT, 32'h0000_0000, 6'd10, 7'd0, 6'd0, '0, "0"},
		'{ROW_TEXT, 32'hFFFF_FFFF, 6'd16, 7'd0, 6'd0, '0, "FFFFFFFF"},
		'{ROW_TEXT, 32'hFFFF_FFFF, 6'd16, 7'd0, 6'd0, F_LOWER | F_PREFIX, "0xffffffff"},
		'{ROW_TEXT, 32'h0000_0000, 6'd16, 7'd0, 6'd0, F_PREFIX, "0X0"},
		'{ROW_TEXT, 32'd255, 6'd8, 7'd0, 6'd0, F_PREFIX, "0377"},
		'{ROW_TEXT, 32'd5, 6'd3, 7'd0, 6'd0, F_PREFIX, "12"},
		'{ROW_TEXT, 32'd35, 6'd36, 7'd0, 6'd0, F_LOWER, "z"},
		'{ROW_TEXT, 32'h8000_0000, 6'd10, 7'd0, 6'd0, F_SIGNED, "-2147483648"},
		'{ROW_TEXT, 32'hFFFF_FFFF, 6'd10, 7'd0, 6'd0, F_SIGNED, "-1"},
		'{ROW_TEXT, 32'h7FFF_FFFF, 6'd10, 7'd0, 6'd0, F_SIGNED | F_PLUS, "+2147483647"},
		'{ROW_TEXT, 32'd100, 6'd10, 7'd0, 6'd0, F_SPACE, " 100"},
		'{ROW_TEXT, 32'd42, 6'd10, 7'd8, 6'd0, '0, "      42"},
		'{ROW_TEXT, 32'd42, 6'd10, 7'd8, 6'd0, F_ZERO | F_PLUS, "+0000042"},
		'{ROW_TEXT, 32'd42, 6'd10, 7'd8, 6'd0, F_LEFT | F_ZERO | F_SPACE, " 42     "},
		'{ROW_TEXT, 32'd42, 6'd10, 7'd0, 6'd5, '0, "00042"},
		'{ROW_TEXT, 32'd26, 6'd16, 7'd8, 6'd4, F_PREFIX | F_ZERO, "0X00001A"},
		'{ROW_TEXT, 32'h8000_0000, 6'd16, 7'd0, 6'd0, 7'h7F, "-0x80000000"},
		'{ROW_PREDICT, 32'hFFFF_FFFF, 6'd2, 7'd0, 6'd0, '0, ""},
		'{ROW_PREDICT, 32'h0000_0000, 6'd10, 7'd64, 6'd32, '0, ""},
		'{ROW_PREDICT, 32'd7, 6'd10, 7'd127, 6'd0, '0, ""},
		'{ROW_PREDICT, 32'd7, 6'd36, 7'd127, 6'd63, F_LEFT, ""},
		'{ROW_PREDICT, 32'hFFFF_FFFF, 6'd2, 7'd127, 6'd63, F_ZERO | F_SIGNED, ""},
		'{ROW_BAD, 32'd12345, 6'd1, 7'd10, 6'd3, F_PLUS, ""},
		'{ROW_BAD, 32'hFFFF_FFFF, 6'd37, 7'd0, 6'd0, '0, ""},
		'{ROW_BAD, 32'hA5A5_A5A5, 6'd63, 7'd127, 6'd63, 7'h7F, ""}
	};

	integer_radix_formatter #(
		.MAX_FIELD(TEXT_MAX),
		.DIGIT_SLOTS(36)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.base(base),
		.min_width(min_width),
		.min_digits(min_digits),
		.format_flags(format_flags),
		.strobe(strobe),
		.out_char(out_char),
		.last_char(last_char),
		.bad_base(bad_base)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Expected text of one printf-style integer conversion, cut to TEXT_MAX characters.
	function automatic char_list_t format_integer(input logic [VAL_W-1:0] num_in,
			input logic [BASE_W-1:0] radix, input logic [FW_W-1:0] width,
			input logic [MD_W-1:0] precision, input logic [FLAGS_W-1:0] flags);
		char_list_t        res;
		logic [VAL_W-1:0]  num;
		logic [FLAGS_W-1:0] fl;
		logic [CHAR_W-1:0] sign_ch;
		logic [CHAR_W-1:0] pad_ch;
		logic [CHAR_W-1:0] digs[$];
		logic [CHAR_W-1:0] text[$];
		string             charset;
		int                size;
		int                prec;
		int                k;
		int                n;
		if (radix < BASE_MIN || radix > BASE_MAX) begin
			res.push_back('{ch: CH_NONE, last: 1'b1, bad: 1'b1});
			return res;
		end
		num = num_in;
		fl = flags;
		size = int'(width);
		prec = int'(precision);
		charset = fl[FLG_LOWER] ? "0123456789abcdefghijklmnopqrstuvwxyz"
			: "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
		if (fl[FLG_LEFT])
			fl[FLG_ZERO] = 1'b0;
		pad_ch = fl[FLG_ZERO] ? CH_ZERO : CH_SPACE;
		sign_ch = CH_NONE;
		if (fl[FLG_SIGNED] && num[VAL_W-1]) begin
			sign_ch = CH_MINUS;
			num = '0 - num;
		end else if (fl[FLG_PLUS]) begin
			sign_ch = CH_PLUS;
		end else if (fl[FLG_SPACE]) begin
			sign_ch = CH_SPACE;
		end
		if (sign_ch != CH_NONE)
			size--;
		if (fl[FLG_PREFIX]) begin
			if (radix == BASE_HEX)
				size -= 2;
			else if (radix == BASE_OCT)
				size--;
		end
		// Collect digits least significant first.
		if (num == '0)
			digs.push_back(CH_ZERO);
		while (num != '0) begin
			digs.push_back(charset[int'(num % radix)]);
			num = num / radix;
		end
		if (digs.size() > prec)
			prec = digs.size();
		size -= prec;
		if (!fl[FLG_ZERO] && !fl[FLG_LEFT])
			for (; size > 0; size--)
				text.push_back(CH_SPACE);
		if (sign_ch != CH_NONE)
			text.push_back(sign_ch);
		if (fl[FLG_PREFIX]) begin
			if (radix == BASE_OCT) begin
				text.push_back(CH_ZERO);
			end else if (radix == BASE_HEX) begin
				text.push_back(CH_ZERO);
				text.push_back(charset[33]);
			end
		end
		if (!fl[FLG_LEFT])
			for (; size > 0; size--)
				text.push_back(pad_ch);
		for (k = prec - digs.size(); k > 0; k--)
			text.push_back(CH_ZERO);
		for (k = digs.size() - 1; k >= 0; k--)
			text.push_back(digs[k]);
		for (; size > 0; size--)
			text.push_back(CH_SPACE);
		n = (text.size() > TEXT_MAX) ? TEXT_MAX : text.size();
		for (k = 0; k < n; k++)
			res.push_back('{ch: text[k], last: (k == n - 1), bad: 1'b0});
		return res;
	endfunction

	function automatic char_list_t typed_chars(input row_kind_t kind, input string s);
		char_list_t res;
		int         k;
		if (kind == ROW_BAD) begin
			res.push_back('{ch: CH_NONE, last: 1'b1, bad: 1'b1});
			return res;
		end
		for (k = 0; k < s.len(); k++)
			res.push_back('{ch: s[k], last: (k == s.len() - 1), bad: 1'b0});
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input logic [CHAR_W-1:0] got,
			input logic [CHAR_W-1:0] want);
		$display("[%0t] mismatch %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
		error_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic issue_cmd(input logic [VAL_W-1:0] v, input logic [BASE_W-1:0] b,
			input logic [FW_W-1:0] w, input logic [MD_W-1:0] p,
			input logic [FLAGS_W-1:0] f, input char_list_t chars);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		value = v;
		base = b;
		min_width = w;
		min_digits = p;
		format_flags = f;
		do
			@(posedge clk);
		while (busy);
		foreach (chars[k])
			pending_chars.push_back(chars[k]);
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		logic [VAL_W-1:0]   v;
		logic [BASE_W-1:0]  b;
		logic [FW_W-1:0]    w;
		logic [MD_W-1:0]    p;
		logic [FLAGS_W-1:0] f;
		repeat (count) begin
			case ($urandom_range(4))
				0: v = $urandom_range(0, 1000);
				1: v = 32'hFFFF_FFFF - $urandom_range(0, 300);
				2: v = 32'h8000_0000 + $urandom_range(0, 3);
				default: v = $urandom();
			endcase
			if ($urandom_range(99) < 8)
				b = $urandom_range(1) ? BASE_W'($urandom_range(0, 1))
					: BASE_W'($urandom_range(37, 63));
			else if ($urandom_range(2) == 0)
				b = $urandom_range(1) ? BASE_OCT : BASE_HEX;
			else
				b = BASE_W'($urandom_range(2, 36));
			w = ($urandom_range(99) < 10) ? FW_W'($urandom_range(0, 127))
				: FW_W'($urandom_range(0, 24));
			p = ($urandom_range(99) < 15) ? MD_W'($urandom_range(0, 63))
				: MD_W'($urandom_range(0, 10));
			f = FLAGS_W'($urandom_range(0, 127));
			issue_cmd(v, b, w, p, f, format_integer(v, b, w, p, f));
		end
	endtask

	always @(posedge clk) begin
		char_res_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				flag_mismatch("unexpected character", out_char, CH_NONE);
			end else begin
				want = pending_chars.pop_front();
				if (out_char !== want.ch)
					flag_mismatch("out_char", out_char, want.ch);
				if (last_char !== want.last)
					flag_mismatch("last_char", {7'd0, last_char}, {7'd0, want.last});
				if (bad_base !== want.bad)
					flag_mismatch("bad_base", {7'd0, bad_base}, {7'd0, want.bad});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		gap_pct = 11;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		base = '0;
		min_width = '0;
		min_digits = '0;
		format_flags = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_PREDICT)
				issue_cmd(directed_rows[r].val, directed_rows[r].radix, directed_rows[r].width,
					directed_rows[r].precision, directed_rows[r].flags,
					format_integer(directed_rows[r].val, directed_rows[r].radix,
						directed_rows[r].width, directed_rows[r].precision,
						directed_rows[r].flags));
			else
				issue_cmd(directed_rows[r].val, directed_rows[r].radix, directed_rows[r].width,
					directed_rows[r].precision, directed_rows[r].flags,
					typed_chars(directed_rows[r].kind, directed_rows[r].text));
		end

		run_random(32);
		gap_pct = 58;
		run_random(32);
		gap_pct = 0;
		run_random(32);
		start = 1'b0;

		// Drain the last characters, then hold a little longer for stray strobes.
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
